// File: sv/givens_rotation_compute_core_macros.svh
// Assertion macros used by the checker file of the Givens rotation core.
`ifndef GIVENS_ROTATION_COMPUTE_CORE_MACROS_SVH
`define GIVENS_ROTATION_COMPUTE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define GRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("givens core check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define GRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("givens core check failed");

`endif

// File: sv/grc_pkg.sv
// Shared widths, payload structs and constants of the Givens rotation core.
package grc_pkg;

	localparam int DATA_WIDTH     = 24;
	localparam int COEF_FRAC_BITS = 30;

	localparam int NORM_W  = DATA_WIDTH + 1;
	localparam int COEF_W  = COEF_FRAC_BITS + 2;
	localparam int S_W     = 2 * DATA_WIDTH;
	localparam int ROOT_W  = (COEF_W > DATA_WIDTH + 2) ? COEF_W : DATA_WIDTH + 2;
	localparam int IDX_W   = $clog2(ROOT_W);
	localparam int PROD_W  = S_W + ROOT_W;
	localparam int RES_W   = S_W + 2 * ROOT_W + 1;
	localparam int FRONT_STAGES = 3;
	localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_W;

	localparam int IN_W   = 2 * DATA_WIDTH;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = NORM_W + 2 * COEF_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

	// One square-root lane: find the largest root with base * root^2 <= target.
	typedef struct packed {
		logic [S_W-1:0]    base;
		logic [RES_W-1:0]  rem;
		logic [PROD_W-1:0] prod;
		logic [ROOT_W-1:0] root;
	} lane_t;

	typedef struct packed {
		lane_t nrm;
		lane_t cy;
		lane_t sz;
	} lane_set_t;

	// Per-request flags and the raw first value for the trivial case.
	typedef struct packed {
		logic                  zero;
		logic                  yneg;
		logic                  zneg;
		logic [DATA_WIDTH-1:0] y;
	} side_t;

endpackage

// File: sv/grc_cell.sv
// One bit cell of the root chain: decides one root bit and passes the lane on.
module grc_cell import grc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [IDX_W-1:0] bit_pos,
	input  lane_t            d,
	output lane_t            q
);

	logic [RES_W-1:0] base_x;
	logic [RES_W-1:0] prod_x;
	logic [RES_W-1:0] inc;
	logic             take;
	lane_t            nxt;
	lane_t            cell_q;

	// Growth of base * root^2 when this bit is set: base*(2*root*2^b + 2^2b).
	always_comb begin
		base_x = RES_W'(d.base) << {bit_pos, 1'b0};
		prod_x = (RES_W'(d.prod) << bit_pos) << 1;
		inc    = base_x + prod_x;
		take   = (inc <= d.rem);
		nxt    = d;
		if (take) begin
			nxt.rem  = d.rem - inc;
			nxt.root = d.root | (ROOT_W'(1) << bit_pos);
			nxt.prod = d.prod + (PROD_W'(d.base) << bit_pos);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule

// File: sv/grc_front.sv
// Front stages: magnitudes, squares, sum of squares and lane targets.
module grc_front import grc_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DATA_WIDTH-1:0] y,
	input  logic [DATA_WIDTH-1:0] z,
	output side_t                 side,
	output lane_set_t             lanes
);

	logic [DATA_WIDTH-1:0] ymag_s1, zmag_s1;
	side_t                 side_s1, side_s2, side_s3;
	logic [S_W-1:0]        sqy_s2, sqz_s2;
	lane_set_t             lanes_s3;
	logic [S_W-1:0]        sum;
	lane_set_t             init;

	// Stage 1: sign flags and magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			ymag_s1      <= y[DATA_WIDTH-1] ? (~y + 1'b1) : y;
			zmag_s1      <= z[DATA_WIDTH-1] ? (~z + 1'b1) : z;
			side_s1.zero <= (z == '0);
			side_s1.yneg <= y[DATA_WIDTH-1];
			side_s1.zneg <= z[DATA_WIDTH-1];
			side_s1.y    <= y;
		end
	end

	// Stage 2: squares of the magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			sqy_s2  <= S_W'(ymag_s1) * S_W'(ymag_s1);
			sqz_s2  <= S_W'(zmag_s1) * S_W'(zmag_s1);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: the norm lane searches sqrt(4S), the coefficient lanes
	// search sqrt(mag^2 * 2^(2F+2) / S).
	always_comb begin
		sum           = sqy_s2 + sqz_s2;
		init.nrm.base = S_W'(1);
		init.nrm.rem  = RES_W'(sum) << 2;
		init.nrm.prod = '0;
		init.nrm.root = '0;
		init.cy.base  = sum;
		init.cy.rem   = RES_W'(sqy_s2) << (2 * COEF_FRAC_BITS + 2);
		init.cy.prod  = '0;
		init.cy.root  = '0;
		init.sz.base  = sum;
		init.sz.rem   = RES_W'(sqz_s2) << (2 * COEF_FRAC_BITS + 2);
		init.sz.prod  = '0;
		init.sz.root  = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s3 <= init;
			side_s3  <= side_s2;
		end
	end

	assign side  = side_s3;
	assign lanes = lanes_s3;

endmodule

// File: sv/givens_rotation_compute_core.sv
// Top level of the pipelined Givens rotation coefficient core.
// Usage:
//   The slave channel takes one request (y, z) per cycle while no result is
//   stalled; s_tdata holds first_value in bits 23:0, second_value in 47:24.
//   The master channel gives one result per request in request order;
//   m_tdata holds rotated_norm, cosine_coef and sine_coef from the low bit up.
//   An accepted request passes three front stages (magnitudes, squares,
//   targets), one cell per root bit in a chain of 32 cells, and the output
//   register before its result shows on m_tvalid.
//   Throughput is one request per cycle while no result stalls, set by the cell
//   chain, in which one cell per lane and root bit resolves that bit and hands on.
//   When z is zero the result is r = y, cosine 1.0, sine 0.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; it rises again in the cycle the result is taken.
//   Reset clears all valid flags; no result is shown until a new request.
module givens_rotation_compute_core import grc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // first_value, second_value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata   // rotated_norm, cosine_coef, sine_coef, pad
);

	logic                  en;
	logic                  vld_q [PIPE_STAGES];
	logic                  out_vld_q;
	logic [OUT_TW-1:0]     out_data_q;
	side_t                 side_f;
	side_t                 side_q [ROOT_W];
	lane_set_t             chain [ROOT_W+1];
	logic [ROOT_W:0]       nrm_inc, cy_inc, sz_inc;
	logic [NORM_W-1:0]     norm_v;
	logic [COEF_W-1:0]     cos_v, sin_v;
	side_t                 sd;

	// The pipeline advances unless a result waits for the receiver.
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	grc_front u_front (
		.clk   (clk),
		.en    (en),
		.y     (s_tdata[DATA_WIDTH-1:0]),
		.z     (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.side  (side_f),
		.lanes (chain[0])
	);

	// Chain of bit cells, most significant root bit first.
	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		localparam logic [IDX_W-1:0] BitPos = IDX_W'(ROOT_W - 1 - i);

		grc_cell u_nrm (.clk(clk), .en(en), .bit_pos(BitPos),
			.d(chain[i].nrm), .q(chain[i+1].nrm));
		grc_cell u_cy (.clk(clk), .en(en), .bit_pos(BitPos),
			.d(chain[i].cy), .q(chain[i+1].cy));
		grc_cell u_sz (.clk(clk), .en(en), .bit_pos(BitPos),
			.d(chain[i].sz), .q(chain[i+1].sz));

		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					side_q[i] <= side_f;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					side_q[i] <= side_q[i-1];
				end
			end
		end
	end

	// Valid flags that follow each request down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				vld_q[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int k = 1; k < PIPE_STAGES; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			out_vld_q <= vld_q[PIPE_STAGES-1];
		end
	end

	// Round the roots to nearest, apply signs, handle a zero second value.
	always_comb begin
		sd      = side_q[ROOT_W-1];
		nrm_inc = {1'b0, chain[ROOT_W].nrm.root} + 1'b1;
		cy_inc  = {1'b0, chain[ROOT_W].cy.root} + 1'b1;
		sz_inc  = {1'b0, chain[ROOT_W].sz.root} + 1'b1;
		norm_v  = NORM_W'(nrm_inc >> 1);
		cos_v   = COEF_W'(cy_inc >> 1);
		sin_v   = COEF_W'(sz_inc >> 1);
		if (sd.yneg) begin
			cos_v = ~cos_v + 1'b1;
		end
		if (sd.zneg) begin
			sin_v = ~sin_v + 1'b1;
		end
		if (sd.zero) begin
			norm_v = {sd.y[DATA_WIDTH-1], sd.y};
			cos_v  = COEF_ONE;
			sin_v  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= OUT_TW'({sin_v, cos_v, norm_v});
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

// File: sv/grc_checker.sv
// Port-level checks of the Givens rotation core and their bind.
`include "givens_rotation_compute_core_macros.svh"

module grc_checker import grc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [IN_TW-1:0]  s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata
);

	logic signed [COEF_W-1:0] cos_f;
	logic signed [COEF_W-1:0] sin_f;

	assign cos_f = m_tdata[NORM_W+COEF_W-1:NORM_W];
	assign sin_f = m_tdata[NORM_W+2*COEF_W-1:NORM_W+COEF_W];

	// An offered request carries known data.
	`GRC_ASSERT_NOW(a_in_known, s_tvalid, !$isunknown(s_tdata))

	// A stalled result stays and holds its data.
	`GRC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// The pipeline takes no request while a result is stalled.
	`GRC_ASSERT_NOW(a_stall, m_tvalid && !m_tready, !s_tready)

	// Coefficients never exceed unit magnitude.
	`GRC_ASSERT_NOW(a_range, m_tvalid,
		cos_f <= $signed(COEF_ONE) && cos_f >= -$signed(COEF_ONE) &&
		sin_f <= $signed(COEF_ONE) && sin_f >= -$signed(COEF_ONE))

	// A zero sine only comes from a zero second value, which gives unit cosine.
	`GRC_ASSERT_NOW(a_trivial, m_tvalid && sin_f == '0, cos_f == $signed(COEF_ONE))

endmodule

bind givens_rotation_compute_core grc_checker u_grc_checker (.*);

// File: bench/givens_rotation_compute_core_test.sv
// Self-checking testbench for the Givens rotation coefficient core.
module givens_rotation_compute_core_test;
	import grc_pkg::*;

	typedef struct packed {
		logic [NORM_W-1:0] norm;
		logic [COEF_W-1:0] cosine;
		logic [COEF_W-1:0] sine;
	} rotation_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;

	rotation_t pending_rotations[$];
	int error_count = 0;
	int cycle_count = 0;
	// Cycles left in a long receive-side stall.
	int stall_left = 0;
	// Stretches without idling on either side.
	bit steady_flow = 1'b0;

	givens_rotation_compute_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Rounded coefficient mag / sqrt(sumsq) scaled by 2^COEF_FRAC_BITS, sign applied.
	function automatic logic [COEF_W-1:0] scaled_ratio(logic [DATA_WIDTH-1:0] mag, logic neg,
			logic [S_W-1:0] sumsq);
		logic [159:0] target;
		logic [159:0] prod;
		logic [31:0] q;
		logic [31:0] cand;
		logic [32:0] rounded;
		if (mag == 0)
			return '0;
		target = (160'(mag) * 160'(mag)) << (2 * COEF_FRAC_BITS + 2);
		q = '0;
		for (int b = COEF_W - 1; b >= 0; b--) begin
			cand = q | (32'd1 << b);
			prod = 160'(sumsq) * 160'(cand) * 160'(cand);
			if (prod <= target)
				q = cand;
		end
		rounded = (33'(q) + 33'd1) >> 1;
		if (neg)
			rounded = -rounded;
		return rounded[COEF_W-1:0];
	endfunction

	// Expected norm and coefficients of the rotation that clears z.
	function automatic rotation_t predict_rotation(logic [DATA_WIDTH-1:0] y,
			logic [DATA_WIDTH-1:0] z);
		rotation_t rot;
		logic [DATA_WIDTH-1:0] ymag;
		logic [DATA_WIDTH-1:0] zmag;
		logic [S_W-1:0] sumsq;
		logic [63:0] four_sum;
		logic [63:0] m;
		logic [63:0] cand;
		if (z == 0) begin
			rot.norm = {y[DATA_WIDTH-1], y};
			rot.cosine = COEF_ONE;
			rot.sine = '0;
			return rot;
		end
		ymag = y[DATA_WIDTH-1] ? -y : y;
		zmag = z[DATA_WIDTH-1] ? -z : z;
		sumsq = S_W'(ymag) * S_W'(ymag) + S_W'(zmag) * S_W'(zmag);
		four_sum = 64'(sumsq) << 2;
		m = 0;
		for (int b = DATA_WIDTH + 1; b >= 0; b--) begin
			cand = m | (64'd1 << b);
			if (cand * cand <= four_sum)
				m = cand;
		end
		rot.norm = NORM_W'((m + 1) >> 1);
		rot.cosine = scaled_ratio(ymag, y[DATA_WIDTH-1], sumsq);
		rot.sine = scaled_ratio(zmag, z[DATA_WIDTH-1], sumsq);
		return rot;
	endfunction

	task automatic report_mismatch(string field, logic [COEF_W-1:0] got,
			logic [COEF_W-1:0] want);
		$display("mismatch in %s: got %h, expected %h", field, got, want);
		error_count++;
	endtask

	// Random gap length: mostly none or short, sometimes long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_flow || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Send one request and hold it until the core takes it.
	task automatic send_pair(logic [DATA_WIDTH-1:0] y, logic [DATA_WIDTH-1:0] z);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= IN_TW'({z, y});
		do
			@(posedge clk);
		while (!s_tready);
		pending_rotations.push_back(predict_rotation(y, z));
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_rotations.size() != 0)
			@(posedge clk);
	endtask

	// Check each taken result and pick the next ready level.
	always @(posedge clk) begin
		rotation_t got;
		rotation_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[NORM_W-1:0], m_tdata[NORM_W +: COEF_W],
				m_tdata[NORM_W + COEF_W +: COEF_W]};
			if (pending_rotations.size() == 0) begin
				report_mismatch("unexpected result", COEF_W'(m_tdata), '0);
			end else begin
				want = pending_rotations.pop_front();
				if (got.norm !== want.norm)
					report_mismatch("rotated_norm", COEF_W'(got.norm), COEF_W'(want.norm));
				if (got.cosine !== want.cosine)
					report_mismatch("cosine_coef", got.cosine, want.cosine);
				if (got.sine !== want.sine)
					report_mismatch("sine_coef", got.sine, want.sine);
			end
		end
		// Occasional long stall on the receive side, otherwise random ready.
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (steady_flow) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 499) == 0) begin
			stall_left = $urandom_range(20, 60);
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) < 70);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_corner_pairs();
		send_pair(24'sd0, 24'sd0);
		send_pair(24'sd5, 24'sd0);
		send_pair(-24'sd8388608, 24'sd0);
		send_pair(24'sd8388607, 24'sd0);
		send_pair(-24'sd1, 24'sd0);
		send_pair(24'sd0, 24'sd1);
		send_pair(24'sd0, -24'sd1);
		send_pair(24'sd0, -24'sd8388608);
		send_pair(24'sd0, 24'sd8388607);
		send_pair(-24'sd8388608, -24'sd8388608);
		send_pair(24'sd8388607, 24'sd8388607);
		send_pair(24'sd8388607, -24'sd8388608);
		send_pair(-24'sd8388608, 24'sd8388607);
		send_pair(24'sd3, 24'sd4);
		send_pair(-24'sd3, 24'sd4);
		send_pair(24'sd3, -24'sd4);
		send_pair(24'sd1, 24'sd1);
		send_pair(-24'sd1, -24'sd1);
		send_pair(24'sd1, 24'sd8388607);
		send_pair(24'sd8388607, 24'sd1);
	endtask

	// Random field values: full range, small magnitudes, extremes and zeros.
	function automatic logic [DATA_WIDTH-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return DATA_WIDTH'($urandom());
		if (roll < 80)
			return DATA_WIDTH'($urandom_range(0, 400)) - DATA_WIDTH'(200);
		if (roll < 90)
			return $urandom_range(0, 1) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
				: {1'b0, {(DATA_WIDTH-1){1'b1}}};
		return '0;
	endfunction

	task automatic test_random_pairs(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				steady_flow = ($urandom_range(0, 3) == 0);
			send_pair(pick_value(), pick_value());
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_pause_until_drained();
		for (int i = 0; i < 40; i++)
			send_pair(pick_value(), pick_value());
		wait_for_results();
		for (int i = 0; i < 40; i++)
			send_pair(pick_value(), pick_value());
	endtask

	task automatic test_full_rate_burst();
		steady_flow = 1'b1;
		for (int i = 0; i < 100; i++)
			send_pair(DATA_WIDTH'($urandom()), DATA_WIDTH'($urandom()));
		steady_flow = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_pairs();
		test_full_rate_burst();
		test_pause_until_drained();
		test_random_pairs(900);
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/grc_pkg.sv
sv/grc_cell.sv
sv/grc_front.sv
sv/givens_rotation_compute_core.sv
sv/grc_checker.sv
bench/givens_rotation_compute_core_test.sv
